### rtl/assert_macros.svh
// assert_macros.svh: shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/rrtss_pkg.sv
// ----------------------------------------------------------------------------
// rrtss_pkg: thread slot scheduler package
// Word types, slot and status codes, and the microcode program of the
// sequencer.
// ----------------------------------------------------------------------------
package rrtss_pkg;

  localparam int SLOTS_DEF = 8;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_YIELD  = 2'd1,
    MODE_EXIT   = 2'd2,
    MODE_JOIN   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BAD_ID  = 2'd2,
    STAT_PENDING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SS_FREE     = 2'd0,
    SS_RUNNABLE = 2'd1,
    SS_RUNNING  = 2'd2,
    SS_DONE     = 2'd3
  } slot_st_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] target_slot;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] created_slot;
    logic       switched;
    logic [2:0] previous_slot;
    logic [2:0] current_slot_out;
  } out_word_t;

  typedef enum logic [2:0] {
    UOP_IDLE,
    UOP_FIND_FREE,
    UOP_MARK_DONE,
    UOP_JOIN,
    UOP_SCAN,
    UOP_DEMOTE,
    UOP_PROMOTE,
    UOP_FINISH
  } uop_t;

  typedef enum logic [1:0] {
    ASEL_CUR,
    ASEL_SCAN,
    ASEL_TGT,
    ASEL_FOUND
  } asel_t;

  typedef logic [2:0] pc_t;

  localparam pc_t PC_IDLE      = 3'd0;
  localparam pc_t PC_FIND_FREE = 3'd1;
  localparam pc_t PC_MARK_DONE = 3'd2;
  localparam pc_t PC_JOIN      = 3'd3;
  localparam pc_t PC_SCAN      = 3'd4;
  localparam pc_t PC_DEMOTE    = 3'd5;
  localparam pc_t PC_PROMOTE   = 3'd6;
  localparam pc_t PC_FINISH    = 3'd7;

  typedef struct packed {
    uop_t     uop;
    asel_t    asel;
    slot_st_t wval;
    pc_t      jmp_pc;
    pc_t      next_pc;
  } uword_t;

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      PC_IDLE:      w = '{UOP_IDLE,      ASEL_CUR,   SS_FREE,     PC_IDLE,   PC_IDLE};
      PC_FIND_FREE: w = '{UOP_FIND_FREE, ASEL_SCAN,  SS_RUNNABLE, PC_FINISH, PC_FINISH};
      PC_MARK_DONE: w = '{UOP_MARK_DONE, ASEL_CUR,   SS_DONE,     PC_SCAN,   PC_SCAN};
      PC_JOIN:      w = '{UOP_JOIN,      ASEL_TGT,   SS_FREE,     PC_FINISH, PC_SCAN};
      PC_SCAN:      w = '{UOP_SCAN,      ASEL_SCAN,  SS_RUNNING,  PC_DEMOTE, PC_FINISH};
      PC_DEMOTE:    w = '{UOP_DEMOTE,    ASEL_CUR,   SS_RUNNABLE, PC_PROMOTE, PC_PROMOTE};
      PC_PROMOTE:   w = '{UOP_PROMOTE,   ASEL_FOUND, SS_RUNNING,  PC_FINISH, PC_FINISH};
      PC_FINISH:    w = '{UOP_FINISH,    ASEL_CUR,   SS_FREE,     PC_IDLE,   PC_IDLE};
      default:      w = '{UOP_IDLE,      ASEL_CUR,   SS_FREE,     PC_IDLE,   PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic pc_t entry_pc(mode_t m);
    pc_t p;
    case (m)
      MODE_CREATE: p = PC_FIND_FREE;
      MODE_YIELD:  p = PC_SCAN;
      MODE_EXIT:   p = PC_MARK_DONE;
      MODE_JOIN:   p = PC_JOIN;
      default:     p = PC_IDLE;
    endcase
    return p;
  endfunction

endpackage

### rtl/round_robin_thread_slot_scheduler.sv
// The sequencer reads one slot of the state table per cycle; a new word is
// taken in the cycle its predecessor's result is shown. The receiver cannot
// stall. Synchronous reset puts slot 0 running and current, all other slots
// free, and the sequencer idle.
// ----------------------------------------------------------------------------
// round_robin_thread_slot_scheduler: thread slot table with round-robin yield
// Microcoded sequencer over a slot state table: create, yield, exit, join.
// ----------------------------------------------------------------------------
module round_robin_thread_slot_scheduler #(
  parameter int SLOTS = rrtss_pkg::SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rrtss_pkg::in_word_t  in_word,
  output logic                 out_valid,
  output rrtss_pkg::out_word_t out_word
);
  import rrtss_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
  localparam logic [4:0] SLOTS_V = 5'(SLOTS);

  slot_st_t      state_r [SLOTS];
  pc_t           pc_r, pc_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] prev_r, prev_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] found_r, found_nxt;
  logic [SW-1:0] created_r, created_nxt;
  logic [3:0]    tgt_r, tgt_nxt;
  status_t       status_r, status_nxt;
  logic          sw_r, sw_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  uword_t        uw;
  logic [SW-1:0] addr;
  slot_st_t      rd;
  logic          we;
  logic          accept;
  logic          free_hit, run_hit, create_end, scan_end, join_bad, join_done;

  function automatic logic [SW-1:0] inc_slot(logic [SW-1:0] x);
    return (x == LAST) ? '0 : x + 1'b1;
  endfunction

  assign uw     = ucode(pc_r);
  assign busy   = (pc_r != PC_IDLE);
  assign accept = start && !busy;

  always_comb begin
    case (uw.asel)
      ASEL_CUR:   addr = cur_r;
      ASEL_SCAN:  addr = scan_r;
      ASEL_TGT:   addr = tgt_r[SW-1:0];
      ASEL_FOUND: addr = found_r;
      default:    addr = cur_r;
    endcase
  end

  assign rd         = state_r[addr];
  assign free_hit   = (rd == SS_FREE);
  assign run_hit    = (rd == SS_RUNNABLE);
  assign join_done  = (rd == SS_DONE);
  assign create_end = (scan_r == LAST);
  assign scan_end   = (cnt_r == LAST);
  assign join_bad   = ({1'b0, tgt_r} >= SLOTS_V);

  // sequencer: next step
  always_comb begin
    case (uw.uop)
      UOP_IDLE:      pc_nxt = accept ? entry_pc(in_word.mode) : PC_IDLE;
      UOP_FIND_FREE: pc_nxt = free_hit ? uw.jmp_pc : (create_end ? uw.next_pc : pc_r);
      UOP_SCAN:      pc_nxt = run_hit ? uw.jmp_pc : (scan_end ? uw.next_pc : pc_r);
      UOP_JOIN:      pc_nxt = (join_bad || join_done) ? uw.jmp_pc : uw.next_pc;
      default:       pc_nxt = uw.next_pc;
    endcase
  end

  // datapath controls
  always_comb begin
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    created_nxt   = created_r;
    tgt_nxt       = tgt_r;
    status_nxt    = status_r;
    sw_nxt        = sw_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    we            = 1'b0;
    case (uw.uop)
      UOP_IDLE: begin
        if (accept) begin
          tgt_nxt     = in_word.target_slot;
          prev_nxt    = cur_r;
          scan_nxt    = (in_word.mode == MODE_CREATE) ? SW'(1) : inc_slot(cur_r);
          cnt_nxt     = '0;
          created_nxt = '0;
          status_nxt  = STAT_OK;
          sw_nxt      = 1'b0;
        end
      end
      UOP_FIND_FREE: begin
        if (free_hit) begin
          we          = 1'b1;
          created_nxt = scan_r;
        end else if (create_end) begin
          status_nxt = STAT_FULL;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      UOP_MARK_DONE: we = 1'b1;
      UOP_JOIN: begin
        if (join_bad) begin
          status_nxt = STAT_BAD_ID;
        end else if (join_done) begin
          we = 1'b1;
        end else begin
          status_nxt = STAT_PENDING;
        end
      end
      UOP_SCAN: begin
        if (run_hit) begin
          found_nxt = scan_r;
        end else if (!scan_end) begin
          scan_nxt = inc_slot(scan_r);
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      UOP_DEMOTE: we = (rd == SS_RUNNING);
      UOP_PROMOTE: begin
        we      = 1'b1;
        cur_nxt = found_r;
        sw_nxt  = (found_r != cur_r);
      end
      UOP_FINISH: begin
        out_valid_nxt                 = 1'b1;
        out_word_nxt.status           = status_r;
        out_word_nxt.created_slot     = 3'(created_r);
        out_word_nxt.switched         = sw_r;
        out_word_nxt.previous_slot    = 3'(prev_r);
        out_word_nxt.current_slot_out = 3'(cur_r);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        state_r[i] <= (i == 0) ? SS_RUNNING : SS_FREE;
      end
      pc_r        <= PC_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (we) begin
        state_r[addr] <= uw.wval;
      end
      pc_r        <= pc_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    scan_r     <= scan_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    created_r  <= created_nxt;
    tgt_r      <= tgt_nxt;
    status_r   <= status_nxt;
    sw_r       <= sw_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/rrtss_checker.sv
// ----------------------------------------------------------------------------
// rrtss_checker: port-level checks for the thread slot scheduler
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrtss_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input rrtss_pkg::out_word_t out_word
);
  import rrtss_pkg::*;

  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `ASSERT_CLK(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `ASSERT_NEVER(a_strobe_idle, out_valid && busy, "result shown while sequencer busy")
  `ASSERT_CLK(a_created_ok,
              (out_valid && out_word.created_slot != 3'd0) |-> (out_word.status == STAT_OK),
              "created slot with failing status")
  `ASSERT_CLK(a_bad_no_switch,
              (out_valid && out_word.status == STAT_BAD_ID) |->
                (!out_word.switched && out_word.previous_slot == out_word.current_slot_out),
              "invalid join changed the current slot")

endmodule

bind round_robin_thread_slot_scheduler rrtss_checker u_rrtss_checker (.*);

### tb/tb_round_robin_thread_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_thread_slot_scheduler: self-checking bench for the scheduler
// A queue-fed driver issues create, yield, exit and join words with random
// gaps; a monitor compares each result word, field by field, with a model of
// the slot table that runs on every accepted word.
// ----------------------------------------------------------------------------
module tb_round_robin_thread_slot_scheduler;
  import rrtss_pkg::*;

  localparam int SLOTS      = SLOTS_DEF;
  localparam int WDOG_LIMIT = 2000;

  typedef struct {
    in_word_t    word;
    bit          drain;
    int unsigned idle_pct;
  } stim_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  stim_t     pending_q[$];
  out_word_t sched_result_q[$];

  slot_st_t   slot_tbl [SLOTS];
  logic [2:0] cur_slot;

  bit        took;
  int        fail_cnt;
  int        idle_cycles;
  int        mode_cnt [4];
  int        switch_cnt;
  int        full_cnt;
  int        bad_id_cnt;
  int        pending_cnt;
  int        freed_cnt;
  out_word_t exp_w;
  out_word_t next_w;

  round_robin_thread_slot_scheduler #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  function automatic bit rr_yield();
    logic [2:0] old_slot;
    int         nxt;
    bit         found;
    bit         moved;
    old_slot = cur_slot;
    found    = 0;
    moved    = 0;
    for (int k = 1; k <= SLOTS; k++) begin
      nxt = (int'(old_slot) + k) % SLOTS;
      if (!found && slot_tbl[nxt] == SS_RUNNABLE) begin
        found = 1;
        if (slot_tbl[old_slot] == SS_RUNNING) slot_tbl[old_slot] = SS_RUNNABLE;
        slot_tbl[nxt] = SS_RUNNING;
        cur_slot      = nxt[2:0];
        moved         = (nxt[2:0] != old_slot);
      end
    end
    return moved;
  endfunction

  task automatic schedule_step(input in_word_t w, output out_word_t r);
    bit found;
    r               = '0;
    r.status        = STAT_OK;
    r.previous_slot = cur_slot;
    case (w.mode)
      MODE_CREATE: begin
        found    = 0;
        r.status = STAT_FULL;
        for (int i = 1; i < SLOTS; i++) begin
          if (!found && slot_tbl[i] == SS_FREE) begin
            found          = 1;
            slot_tbl[i]    = SS_RUNNABLE;
            r.created_slot = i[2:0];
            r.status       = STAT_OK;
          end
        end
      end
      MODE_YIELD: r.switched = rr_yield();
      MODE_EXIT: begin
        slot_tbl[cur_slot] = SS_DONE;
        r.switched         = rr_yield();
      end
      default: begin
        if (int'(w.target_slot) >= SLOTS) begin
          r.status = STAT_BAD_ID;
        end else if (slot_tbl[w.target_slot] == SS_DONE) begin
          slot_tbl[w.target_slot] = SS_FREE;
        end else begin
          r.switched = rr_yield();
          r.status   = STAT_PENDING;
        end
      end
    endcase
    r.current_slot_out = cur_slot;
  endtask

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, expv, actv);
      fail_cnt++;
    end
  endtask

  function automatic in_word_t rand_word();
    in_word_t    w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30)      w.mode = MODE_CREATE;
    else if (r < 55) w.mode = MODE_YIELD;
    else if (r < 75) w.mode = MODE_EXIT;
    else             w.mode = MODE_JOIN;
    if (w.mode == MODE_JOIN && $urandom_range(9) != 0) begin
      w.target_slot = 4'($urandom_range(SLOTS - 1));
    end else begin
      w.target_slot = 4'($urandom_range(15));
    end
    return w;
  endfunction

  task automatic add_item(input mode_t m, input logic [3:0] tgt, input bit drain,
                          input int unsigned idle_pct);
    stim_t s;
    s.word.mode        = m;
    s.word.target_slot = tgt;
    s.drain            = drain;
    s.idle_pct         = idle_pct;
    pending_q.push_back(s);
  endtask

  // driver: present words at the falling edge, hold until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      took = 0;
    end else if (!start || took) begin
      took = 0;
      if (pending_q.size() != 0 &&
          !(pending_q[0].drain && sched_result_q.size() != 0) &&
          $urandom_range(99) >= pending_q[0].idle_pct) begin
        start   <= 1'b1;
        in_word <= pending_q[0].word;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: accept words, predict, check results
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (out_valid) begin
        idle_cycles = 0;
        if (sched_result_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %p", $time, out_word);
          fail_cnt++;
        end else begin
          exp_w = sched_result_q.pop_front();
          check_field("status", exp_w.status, out_word.status);
          check_field("created_slot", exp_w.created_slot, out_word.created_slot);
          check_field("switched", exp_w.switched, out_word.switched);
          check_field("previous_slot", exp_w.previous_slot, out_word.previous_slot);
          check_field("current_slot_out", exp_w.current_slot_out, out_word.current_slot_out);
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        schedule_step(in_word, next_w);
        sched_result_q.push_back(next_w);
        void'(pending_q.pop_front());
        took = 1;
        mode_cnt[in_word.mode]++;
        if (next_w.switched) switch_cnt++;
        case (next_w.status)
          STAT_FULL:    full_cnt++;
          STAT_BAD_ID:  bad_id_cnt++;
          STAT_PENDING: pending_cnt++;
          default:      if (in_word.mode == MODE_JOIN) freed_cnt++;
        endcase
      end
    end
  end

  initial begin
    while (idle_cycles < WDOG_LIMIT) @(posedge clk);
    $display("%0t: watchdog expired with %0d words pending and %0d results outstanding",
             $time, pending_q.size(), sched_result_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_idle [4];
    clk      = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_word  = '0;
    took     = 0;
    fail_cnt = 0;
    for (int i = 0; i < SLOTS; i++) slot_tbl[i] = SS_FREE;
    slot_tbl[0] = SS_RUNNING;
    cur_slot    = '0;

    // directed: empty table, invalid ids, exit with nothing runnable, fill, drain
    add_item(MODE_YIELD,  4'd0,  0, 0);
    add_item(MODE_JOIN,   4'd15, 0, 0);
    add_item(MODE_JOIN,   4'd8,  0, 0);
    add_item(MODE_JOIN,   4'd0,  0, 0);
    add_item(MODE_EXIT,   4'd15, 0, 0);
    add_item(MODE_YIELD,  4'd0,  0, 0);
    add_item(MODE_CREATE, 4'd0,  0, 0);
    add_item(MODE_YIELD,  4'd0,  0, 0);
    add_item(MODE_JOIN,   4'd0,  0, 0);
    for (int i = 0; i < 7; i++) add_item(MODE_CREATE, 4'(i), 0, 0);
    add_item(MODE_YIELD,  4'd0,  0, 0);
    add_item(MODE_JOIN,   4'd5,  0, 0);
    add_item(MODE_EXIT,   4'd0,  0, 0);
    add_item(MODE_JOIN,   4'd3,  0, 0);
    add_item(MODE_JOIN,   4'd0,  0, 0);
    add_item(MODE_CREATE, 4'd0,  0, 0);
    add_item(MODE_JOIN,   4'd7,  0, 0);
    add_item(MODE_JOIN,   4'd12, 0, 0);

    phase_idle = '{0, 72, 19, 0};
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < 100; n++) begin
        stim_t s;
        s.word     = rand_word();
        s.drain    = (n == 0);
        s.idle_pct = phase_idle[p];
        pending_q.push_back(s);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || sched_result_q.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    $display("Ran %0d create, %0d yield, %0d exit, %0d join words with %0d slot switches",
             mode_cnt[MODE_CREATE], mode_cnt[MODE_YIELD], mode_cnt[MODE_EXIT],
             mode_cnt[MODE_JOIN], switch_cnt);
    $display("Table full %0d times, bad ids %0d, joins pending %0d, slots freed by join %0d",
             full_cnt, bad_id_cnt, pending_cnt, freed_cnt);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
